// ===== rtl/lcp_pkg.sv =====
// ----------------------------------------------------------------------------
// Lattice coefficient packer package
// Shared widths, constants, mode codes and the packed group type.
// ----------------------------------------------------------------------------
`default_nettype none

package lcp_pkg;

   // Field widths.
   localparam int COEF_W  = 16;
   localparam int VAL_W   = 14;
   localparam int BYTE_W  = 8;
   localparam int COMP_W  = 3;
   localparam int GROUP_W = 56;
   localparam int NBYTE_W = 3;

   // Modulus and the constants derived from it.
   localparam int MODULUS   = 12289;
   localparam int HALF_MOD  = MODULUS / 2;
   localparam int QUOT_MAX  = 65535 / MODULUS;
   localparam int COMP_MAX  = 8;

   // Group geometry.
   localparam int STORE_DEPTH = 7;
   localparam logic [2:0] FULL_LAST_POS = 3'd3;
   localparam logic [2:0] COMP_LAST_POS = 3'd7;
   localparam logic [NBYTE_W-1:0] FULL_BYTES = 3'd7;
   localparam logic [NBYTE_W-1:0] COMP_BYTES = 3'd3;

   // Mode register codes.
   localparam logic MODE_FULL     = 1'b0;
   localparam logic MODE_COMPRESS = 1'b1;

   // One finished group: its packed bits and how many bytes it holds.
   typedef struct packed {
      logic [GROUP_W-1:0] data;
      logic [NBYTE_W-1:0] nbytes;
   } group_type;

endpackage

`default_nettype wire

// ===== rtl/lattice_coefficient_packer.sv =====
// ----------------------------------------------------------------------------
// Lattice coefficient packer
// Serializes polynomial coefficients reduced modulo q into packed bytes.
// ----------------------------------------------------------------------------
// Requests enter on req_push/req_full, one 16-bit coefficient each; results
// leave on rsp_empty/rsp_pop, one byte each, with rsp_group_last on the
// final byte of a group. csr_wr_en/csr_wr_data write the pack mode
// (0 = four 14-bit values into 7 bytes, 1 = eight 3-bit values into 3 bytes)
// and restart the group; write it only while the block is idle.
// The front end takes one request per cycle while the group queue has room.
// A group's first byte reaches the result ports through the front end's
// value register, the group queue and the back end's shift register.
// The back end emits one byte per cycle while the receiver pops, so full
// mode is limited by the single byte output port (7 bytes per 4 requests);
// compress mode sustains one request per cycle.
// A two-group queue sits between front and back. When the receiver stops
// popping, the queue fills and then req_full rises; nothing is dropped.
// Reset clears the mode to full packing, the group position and all valid
// state; stored coefficient values are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module lattice_coefficient_packer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic [lcp_pkg::COEF_W-1:0]  req_coefficient,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output logic [lcp_pkg::BYTE_W-1:0]       rsp_packed_byte,
   output logic                             rsp_group_last,
   input  wire logic                        csr_wr_en,
   input  wire logic                        csr_wr_data
);

   logic               f_valid, f_ready;
   lcp_pkg::group_type f_data;
   logic               b_valid, b_take;
   lcp_pkg::group_type b_data;

   // Front end: reduce, compress and gather.
   lcp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_coefficient (req_coefficient),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .grp_valid       (f_valid),
      .grp_data        (f_data),
      .grp_ready       (f_ready)
   );

   // Group queue between the two ends.
   lcp_group_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (f_valid),
      .wr_data  (f_data),
      .wr_ready (f_ready),
      .rd_valid (b_valid),
      .rd_data  (b_data),
      .rd_take  (b_take)
   );

   // Back end: byte serializer.
   lcp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .grp_valid       (b_valid),
      .grp_data        (b_data),
      .grp_take        (b_take),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_group_last  (rsp_group_last)
   );

endmodule

`default_nettype wire

// ===== rtl/lcp_front.sv =====
// ----------------------------------------------------------------------------
// Lattice coefficient packer front end
// Reduces each coefficient modulo q, compresses it in compress mode, and
// gathers values until a group is complete, then hands the packed group on.
// ----------------------------------------------------------------------------
`default_nettype none

module lcp_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic [lcp_pkg::COEF_W-1:0]  req_coefficient,
   input  wire logic                        csr_wr_en,
   input  wire logic                        csr_wr_data,
   output logic                             grp_valid,
   output lcp_pkg::group_type               grp_data,
   input  wire logic                        grp_ready
);

   logic                          mode_ff;
   logic                          a_valid_ff, a_valid_in;
   logic [lcp_pkg::VAL_W-1:0]     a_val_ff;
   logic [2:0]                    pos_ff, pos_in;
   logic [lcp_pkg::VAL_W-1:0]     store_ff [lcp_pkg::STORE_DEPTH];

   logic [lcp_pkg::COEF_W-1:0]    sub_val;
   logic [lcp_pkg::VAL_W-1:0]     reduced;
   logic [17:0]                   comp_num;
   logic [3:0]                    comp_quot;
   logic [lcp_pkg::COMP_W-1:0]    comp_val;
   logic                          accept, b_take, complete;
   logic [lcp_pkg::VAL_W-1:0]     store_val;

   // Full reduction: pick the largest multiple of q not above the input.
   always_comb begin
      sub_val = '0;
      for (int k = 1; k <= lcp_pkg::QUOT_MAX; k++) begin
         if (17'({1'b0, req_coefficient}) >= 17'(k * lcp_pkg::MODULUS)) begin
            sub_val = 16'(k * lcp_pkg::MODULUS);
         end
      end
      reduced = lcp_pkg::VAL_W'(req_coefficient - sub_val);
   end

   // Rounding to three bits: count the thresholds passed, then wrap at eight.
   always_comb begin
      comp_num  = 18'({a_val_ff, 3'b000}) + 18'(lcp_pkg::HALF_MOD);
      comp_quot = '0;
      for (int k = 1; k <= lcp_pkg::COMP_MAX; k++) begin
         if (comp_num >= 18'(k * lcp_pkg::MODULUS)) begin
            comp_quot = 4'(k);
         end
      end
      comp_val = comp_quot[lcp_pkg::COMP_W-1:0];
   end

   // Stage handshake: the gather stage stalls only on a full group queue.
   always_comb begin
      complete = (mode_ff == lcp_pkg::MODE_FULL) ? (pos_ff == lcp_pkg::FULL_LAST_POS)
                                                  : (pos_ff == lcp_pkg::COMP_LAST_POS);
      b_take     = a_valid_ff && (!complete || grp_ready);
      req_full   = a_valid_ff && !b_take;
      accept     = req_push && !req_full;
      a_valid_in = accept || (a_valid_ff && !b_take);
      store_val  = (mode_ff == lcp_pkg::MODE_FULL) ? a_val_ff
                                                   : lcp_pkg::VAL_W'(comp_val);
   end

   // Packed group, least significant bits first.
   always_comb begin
      grp_valid = a_valid_ff && complete;
      if (mode_ff == lcp_pkg::MODE_FULL) begin
         grp_data.data   = {a_val_ff, store_ff[2], store_ff[1], store_ff[0]};
         grp_data.nbytes = lcp_pkg::FULL_BYTES;
      end else begin
         grp_data.data   = lcp_pkg::GROUP_W'({comp_val,
                              store_ff[6][2:0], store_ff[5][2:0], store_ff[4][2:0],
                              store_ff[3][2:0], store_ff[2][2:0], store_ff[1][2:0],
                              store_ff[0][2:0]});
         grp_data.nbytes = lcp_pkg::COMP_BYTES;
      end
   end

   // Group position: a mode write restarts the group.
   always_comb begin
      pos_in = pos_ff;
      if (csr_wr_en) begin
         pos_in = '0;
      end else if (b_take) begin
         pos_in = complete ? 3'd0 : pos_ff + 3'd1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= lcp_pkg::MODE_FULL;
         a_valid_ff <= 1'b0;
         pos_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         a_valid_ff <= a_valid_in;
         pos_ff     <= pos_in;
      end
   end

   // Reduced value register and the gather store.
   always_ff @(posedge clock) begin
      if (accept) begin
         a_val_ff <= reduced;
      end
      if (b_take && !complete) begin
         store_ff[pos_ff] <= store_val;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lcp_group_fifo.sv =====
// ----------------------------------------------------------------------------
// Lattice coefficient packer group queue
// Two-entry queue of packed groups between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module lcp_group_fifo (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_valid,
   input  wire lcp_pkg::group_type wr_data,
   output logic               wr_ready,
   output logic               rd_valid,
   output lcp_pkg::group_type rd_data,
   input  wire logic          rd_take
);

   lcp_pkg::group_type entry_ff [2];
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         count_ff;
   logic               do_wr, do_rd;

   // Occupancy flags.
   always_comb begin
      wr_ready = (count_ff != 2'd2);
      rd_valid = (count_ff != 2'd0);
      rd_data  = entry_ff[rd_ptr_ff];
      do_wr    = wr_valid && wr_ready;
      do_rd    = rd_take && rd_valid;
   end

   // Pointers and count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_rd) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lcp_back.sv =====
// ----------------------------------------------------------------------------
// Lattice coefficient packer back end
// Loads one packed group at a time and shifts it out a byte per cycle as the receiver pops.
// ----------------------------------------------------------------------------
`default_nettype none

module lcp_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        grp_valid,
   input  wire lcp_pkg::group_type          grp_data,
   output logic                             grp_take,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output logic [lcp_pkg::BYTE_W-1:0]       rsp_packed_byte,
   output logic                             rsp_group_last
);

   logic [lcp_pkg::GROUP_W-1:0] shift_ff;
   logic [lcp_pkg::NBYTE_W-1:0] count_ff;
   logic                        pop_ok;

   // Output view and load decision: refill when empty or as the last byte leaves.
   always_comb begin
      rsp_empty       = (count_ff == '0);
      rsp_packed_byte = shift_ff[lcp_pkg::BYTE_W-1:0];
      rsp_group_last  = (count_ff == lcp_pkg::NBYTE_W'(1));
      pop_ok          = rsp_pop && !rsp_empty;
      grp_take        = grp_valid && (rsp_empty || (rsp_group_last && pop_ok));
   end

   // Remaining byte count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (grp_take) begin
         count_ff <= grp_data.nbytes;
      end else if (pop_ok) begin
         count_ff <= count_ff - lcp_pkg::NBYTE_W'(1);
      end
   end

   // Byte shifter.
   always_ff @(posedge clock) begin
      if (grp_take) begin
         shift_ff <= grp_data.data;
      end else if (pop_ok) begin
         shift_ff <= shift_ff >> lcp_pkg::BYTE_W;
      end
   end

endmodule

`default_nettype wire

// ===== tb/lcp_checker.sv =====
// ----------------------------------------------------------------------------
// Lattice coefficient packer checker
// Watches the request, result and mode register ports of the packer. It
// keeps its own copy of the mode and of the group being gathered, predicts
// the packed bytes of every finished group, and compares each popped byte
// with the oldest prediction.
// ----------------------------------------------------------------------------
module lcp_checker
   import lcp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  logic [COEF_W-1:0] req_coefficient,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  logic [BYTE_W-1:0] rsp_packed_byte,
   input  logic              rsp_group_last,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   output int                fail_count,
   output int                outstanding,
   output int                bytes_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   // One predicted output byte.
   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              last;
   } packed_byte_t;

   logic              pack_mode;
   logic [2:0]        position;
   logic [VAL_W-1:0]  held [STORE_DEPTH];
   packed_byte_t      expected_bytes [$];

   initial begin
      fail_count    = 0;
      outstanding   = 0;
      bytes_checked = 0;
      pack_mode     = MODE_FULL;
      position      = '0;
   end

   // Prints one line about a failure and counts it.
   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      fail_count++;
   endtask

   // Reduces a raw coefficient, gathers it into the current group and, when
   // the group is complete, queues the bytes the packer has to emit.
   task automatic pack_coefficient(input logic [COEF_W-1:0] raw);
      int unsigned       residue;
      int unsigned       level;
      logic [GROUP_W-1:0] full_bits;
      logic [23:0]       comp_bits;
      packed_byte_t      b;
      residue = int'(raw) % MODULUS;
      if (pack_mode == MODE_FULL) begin
         if (position != FULL_LAST_POS) begin
            held[position] = residue[VAL_W-1:0];
            position = position + 3'd1;
         end else begin
            // Coefficient i sits at bits 14*i and up, least significant first.
            full_bits = {residue[VAL_W-1:0], held[2], held[1], held[0]};
            for (int k = 0; k < int'(FULL_BYTES); k++) begin
               b.value = full_bits[8*k +: 8];
               b.last  = (k == int'(FULL_BYTES) - 1);
               expected_bytes.push_back(b);
            end
            position = '0;
         end
      end else begin
         // Round 8r/q to the nearest integer; eight wraps around to zero.
         level = (((residue << 3) + (MODULUS / 2)) / MODULUS) & 32'h7;
         if (position != COMP_LAST_POS) begin
            held[position] = VAL_W'(level);
            position = position + 3'd1;
         end else begin
            comp_bits = {level[COMP_W-1:0], held[6][COMP_W-1:0], held[5][COMP_W-1:0],
                         held[4][COMP_W-1:0], held[3][COMP_W-1:0], held[2][COMP_W-1:0],
                         held[1][COMP_W-1:0], held[0][COMP_W-1:0]};
            for (int k = 0; k < int'(COMP_BYTES); k++) begin
               b.value = comp_bits[8*k +: 8];
               b.last  = (k == int'(COMP_BYTES) - 1);
               expected_bytes.push_back(b);
            end
            position = '0;
         end
      end
   endtask

   // Compares a popped byte with the oldest prediction, field by field.
   task automatic check_popped_byte();
      packed_byte_t want;
      if (expected_bytes.size() == 0) begin
         report_mismatch($sformatf("byte 0x%02h popped with nothing predicted",
                                   rsp_packed_byte));
      end else begin
         want = expected_bytes.pop_front();
         bytes_checked++;
         if (rsp_packed_byte !== want.value)
            report_mismatch($sformatf("packed_byte expected 0x%02h got 0x%02h",
                                      want.value, rsp_packed_byte));
         if (rsp_group_last !== want.last)
            report_mismatch($sformatf("group_last expected %0b got %0b",
                                      want.last, rsp_group_last));
      end
   endtask

   // Follow every handshake and register write at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         pack_mode = MODE_FULL;
         position  = '0;
         expected_bytes.delete();
      end else begin
         if (rsp_pop && !rsp_empty) check_popped_byte();
         if (csr_wr_en) begin
            pack_mode = csr_wr_data;
            position  = '0;
         end
         if (req_push && !req_full) pack_coefficient(req_coefficient);
      end
      outstanding = expected_bytes.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Lattice coefficient packer testbench
// Drives coefficient requests and mode writes into the packer, pops its
// bytes with random stalls, and lets the checker predict and compare. A
// directed opening covers field extremes, modulus and rounding edges and
// dropped partial groups; random phases in both modes follow.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lcp_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;
   localparam int ITEM_TARGET = 380;
   localparam int CALM_AFTER  = 320;

   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_push        = 1'b0;
   logic              req_full;
   logic [COEF_W-1:0] req_coefficient = '0;
   logic              rsp_empty;
   logic              rsp_pop         = 1'b0;
   logic [BYTE_W-1:0] rsp_packed_byte;
   logic              rsp_group_last;
   logic              csr_wr_en       = 1'b0;
   logic              csr_wr_data     = 1'b0;

   int fail_count;
   int outstanding;
   int bytes_checked;
   int items_sent  = 0;
   int mode_writes = 0;
   int quiet_cycles = 0;

   logic sender_idles   = 1'b0;
   logic receiver_idles = 1'b0;
   logic rsp_hold_off   = 1'b0;

   lattice_coefficient_packer u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_coefficient (req_coefficient),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_group_last  (rsp_group_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   lcp_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_coefficient (req_coefficient),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_group_last  (rsp_group_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .bytes_checked   (bytes_checked)
   );

   always #10 clock = ~clock;

   // Receiver: pops every cycle except during idle bursts and the long hold.
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_off) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            rsp_hold_off = 1'b0;
         end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clock);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run when nothing has been accepted for too long.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_wr_en || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   // Picks a coefficient, weighted toward multiples of q, field extremes and rounding edges.
   function automatic logic [COEF_W-1:0] random_coefficient();
      int v;
      int k;
      case ($urandom_range(0, 5))
         1: begin
            v = $urandom_range(0, 5) * MODULUS + $urandom_range(0, 4) - 2;
         end
         2: begin
            case ($urandom_range(0, 3))
               0:       v = 0;
               1:       v = 65535;
               2:       v = MODULUS - 1;
               default: v = MODULUS;
            endcase
         end
         3: begin
            k = $urandom_range(1, 8);
            v = (k * MODULUS - MODULUS / 2 + 7) / 8 - $urandom_range(0, 1)
                + $urandom_range(0, 4) * MODULUS;
         end
         default: v = $urandom_range(0, 65535);
      endcase
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return COEF_W'(v);
   endfunction

   // Offers one request and waits for it to be accepted.
   task automatic send_coefficient(input logic [COEF_W-1:0] value);
      int gap;
      @(negedge clock);
      req_push        <= 1'b1;
      req_coefficient <= value;
      do @(posedge clock); while (req_full);
      items_sent++;
      if (sender_idles && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 13);
         @(negedge clock);
         req_push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Writes the pack mode once every predicted byte has been popped.
   task automatic write_mode(input logic mode);
      @(negedge clock);
      req_push <= 1'b0;
      wait (outstanding == 0);
      repeat (8) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      mode_writes++;
   endtask

   // Stimulus and verdict.
   initial begin
      logic [COEF_W-1:0] full_edges [8] = '{16'd0, 16'd65535, 16'd12288, 16'd12289,
                                             16'd24577, 16'd36867, 16'h5555, 16'hAAAA};
      logic [COEF_W-1:0] comp_edges [8] = '{16'd0, 16'd768, 16'd769, 16'd2305,
                                             16'd11520, 16'd11521, 16'd12288, 16'd65535};
      logic [COEF_W-1:0] restart_set [4] = '{16'd12287, 16'd8191, 16'd49155, 16'd32768};
      logic              mode;
      int                group_len;
      int                count;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: full packing straight out of reset, with field extremes.
      foreach (full_edges[i]) send_coefficient(full_edges[i]);
      // A partial group is dropped by a write of the same mode.
      send_coefficient(16'd61444);
      send_coefficient(16'd61445);
      write_mode(MODE_FULL);
      foreach (restart_set[i]) send_coefficient(restart_set[i]);
      // Compression rounding edges, including the wrap from eight to zero.
      write_mode(MODE_COMPRESS);
      foreach (comp_edges[i]) send_coefficient(comp_edges[i]);
      repeat (3) send_coefficient(random_coefficient());

      // Receiver holds off while the sender keeps pushing, so the block fills.
      write_mode(MODE_FULL);
      rsp_hold_off = 1'b1;
      repeat (48) send_coefficient(random_coefficient());
      // Sender pauses until every predicted byte has come out.
      @(negedge clock);
      req_push <= 1'b0;
      wait (outstanding == 0);

      // Random phases: mostly whole groups, sometimes a dropped partial one.
      while (items_sent < ITEM_TARGET) begin
         mode = $urandom_range(0, 1);
         write_mode(mode);
         sender_idles   = (items_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
         receiver_idles = (items_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
         group_len = (mode == MODE_FULL) ? 4 : 8;
         count = group_len * $urandom_range(1, (mode == MODE_FULL) ? 6 : 3);
         if ($urandom_range(0, 4) == 0) count += $urandom_range(1, group_len - 1);
         repeat (count) send_coefficient(random_coefficient());
      end

      @(negedge clock);
      req_push <= 1'b0;
      wait (outstanding == 0);
      repeat (20) @(posedge clock);

      $display("Run covered %0d coefficient requests over %0d mode writes in both modes.",
               items_sent, mode_writes);
      $display("%0d packed bytes were checked, with a full-stall phase and a drain pause.",
               bytes_checked);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/lcp_pkg.sv
rtl/lcp_front.sv
rtl/lcp_group_fifo.sv
rtl/lcp_back.sv
rtl/lattice_coefficient_packer.sv
tb/lcp_checker.sv
tb/tb_top.sv
